// ===== sv/lbb_pkg.sv =====
// Shared types and constants for the longitudinal bucket barrier.
package lbb_pkg;

	localparam int LBB_Z_FRAC_BITS   = 16;
	localparam int LBB_MOM_FRAC_BITS = 24;
	localparam int LBB_LEN_W         = 31;
	localparam int LBB_REM_NB        = 33;
	localparam int LBB_SQ_W          = 64;

	typedef struct packed {
		logic        particle_valid;
		logic [31:0] z_pos;
		logic [31:0] px_mom;
		logic [31:0] py_mom;
		logic [31:0] dp_over_p;
	} item_t;

	typedef struct packed {
		logic [31:0] z_out;
		logic [31:0] dp_out;
		logic        reflected;
		logic        momentum_error;
	} result_t;

	// Sideband alongside the remainder pipeline.
	typedef struct packed {
		logic                 outside;
		logic                 pos;
		logic                 rneg;
		logic [LBB_LEN_W-2:0] half;
		logic [31:0]          ad;
		logic [31:0]          apx;
		logic [31:0]          apy;
		logic [31:0]          z;
		logic [31:0]          dp;
	} rem_sb_t;

	// Sideband alongside the inner root.
	typedef struct packed {
		logic        outside;
		logic        err;
		logic [63:0] d2;
		logic [31:0] z_new;
		logic [31:0] z;
		logic [31:0] dp;
	} isq1_sb_t;

	// Sideband alongside the outer root.
	typedef struct packed {
		logic        outside;
		logic        err;
		logic [31:0] z_new;
		logic [31:0] z;
		logic [31:0] dp;
	} isq2_sb_t;

endpackage

// ===== sv/lbb_rem.sv =====
// Pipelined restoring remainder, one dividend bit per stage.
module lbb_rem import lbb_pkg::*; #(
	parameter int NB  = LBB_REM_NB,
	parameter int DW  = LBB_LEN_W,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  logic [NB-1:0]  in_num,
	input  logic [DW-1:0]  in_den,
	input  logic [SBW-1:0] in_sb,
	output logic           out_vld,
	output logic [DW-1:0]  out_rem,
	output logic [SBW-1:0] out_sb
);

	logic           vld_s [NB+1];
	logic [NB-1:0]  num_s [NB+1];
	logic [DW-1:0]  rem_s [NB+1];
	logic [SBW-1:0] sb_s  [NB+1];

	assign vld_s[0] = in_vld;
	assign num_s[0] = in_num;
	assign rem_s[0] = '0;
	assign sb_s[0]  = in_sb;

	// Divisor is the config register; the user must keep it stable while items are in flight (not enforced here).
	for (genvar g = 0; g < NB; g++) begin : g_stage
		logic [DW:0] trial;
		logic [DW:0] diff;
		assign trial = {rem_s[g], num_s[g][NB-1-g]};
		assign diff  = trial - {1'b0, in_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			num_s[g+1] <= num_s[g];
			sb_s[g+1]  <= sb_s[g];
			if (trial >= {1'b0, in_den}) begin
				rem_s[g+1] <= diff[DW-1:0];
			end else begin
				rem_s[g+1] <= trial[DW-1:0];
			end
		end
	end

	assign out_vld = vld_s[NB];
	assign out_rem = rem_s[NB];
	assign out_sb  = sb_s[NB];

endmodule

// ===== sv/lbb_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module lbb_isqrt import lbb_pkg::*; #(
	parameter int W   = LBB_SQ_W,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  logic [W-1:0]   in_x,
	input  logic [SBW-1:0] in_sb,
	output logic           out_vld,
	output logic [W/2-1:0] out_root,
	output logic [SBW-1:0] out_sb
);

	localparam int N = W / 2;

	logic           vld_s [N+1];
	logic [W-1:0]   x_s   [N+1];
	logic [W-1:0]   res_s [N+1];
	logic [SBW-1:0] sb_s  [N+1];

	assign vld_s[0] = in_vld;
	assign x_s[0]   = in_x;
	assign res_s[0] = '0;
	assign sb_s[0]  = in_sb;

	for (genvar g = 0; g < N; g++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * g);
		logic [W-1:0] trial;
		assign trial = res_s[g] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			sb_s[g+1] <= sb_s[g];
			if (x_s[g] >= trial) begin
				x_s[g+1]   <= x_s[g] - trial;
				res_s[g+1] <= (res_s[g] >> 1) + BIT;
			end else begin
				x_s[g+1]   <= x_s[g];
				res_s[g+1] <= res_s[g] >> 1;
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = res_s[N][W/2-1:0];
	assign out_sb   = sb_s[N];

endmodule

// ===== sv/longitudinal_bucket_barrier_unit.sv =====
// Top level of the longitudinal bucket barrier: reflect z, rebuild dp/p.
//
//  channel  | ports                 | handshake
//  ---------+-----------------------+-----------------------------------
//  item     | start, busy, item     | beat taken when start & !busy
//  result   | done, result          | one-cycle strobe, no backpressure
//  config   | cfg_we, cfg_wdata     | bucket_length written when cfg_we
//
// One particle enters every cycle; busy is always low. Items pass through
// the 33-stage remainder and the two 32-stage square roots.
// Reset clears all valid bits and loads bucket_length with 1.0.
// Nothing stalls: the receiver takes every done beat as it comes.
module longitudinal_bucket_barrier_unit import lbb_pkg::*; #(
	parameter int Z_FRAC_BITS   = LBB_Z_FRAC_BITS,
	parameter int MOM_FRAC_BITS = LBB_MOM_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [LBB_LEN_W-1:0] cfg_wdata
);

	localparam logic [LBB_LEN_W-1:0] LEN_RST = LBB_LEN_W'(1) << Z_FRAC_BITS;
	localparam logic signed [32:0]   ONE33   = 33'(1) << MOM_FRAC_BITS;
	localparam logic [63:0]          FOUR_SQ = 64'(4) << (2 * MOM_FRAC_BITS);

	logic [LBB_LEN_W-1:0] bucket_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_length_q <= LEN_RST;
		end else if (cfg_we) begin
			bucket_length_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// ---- stage 1: capture the beat
	logic  vld_s1;
	item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	// ---- stage 2: bucket test, remainder dividend, absolute momenta
	logic [LBB_LEN_W-2:0]  half_c;
	logic signed [32:0]    z_c, half_x_c, num_c, d_c;
	logic                  outside_c, pos_c;
	logic [32:0]           mag_c, ad_c;
	rem_sb_t               sb_c;

	always_comb begin
		half_c    = bucket_length_q[LBB_LEN_W-1:1];
		z_c       = 33'(signed'(item_s1.z_pos));
		half_x_c  = signed'({3'b000, half_c});
		pos_c     = z_c > half_x_c;
		outside_c = item_s1.particle_valid && (bucket_length_q != '0)
			&& (pos_c || (z_c < -half_x_c));
		num_c     = pos_c ? (z_c + half_x_c) : (z_c - half_x_c);
		mag_c     = num_c[32] ? 33'(-num_c) : 33'(num_c);
		d_c       = 33'(signed'(item_s1.dp_over_p)) + ONE33;
		ad_c      = d_c[32] ? 33'(-d_c) : 33'(d_c);

		sb_c.outside = outside_c;
		sb_c.pos     = pos_c;
		sb_c.rneg    = num_c[32];
		sb_c.half    = half_c;
		sb_c.ad      = ad_c[31:0];
		sb_c.apx     = item_s1.px_mom[31] ? 32'(-item_s1.px_mom) : item_s1.px_mom;
		sb_c.apy     = item_s1.py_mom[31] ? 32'(-item_s1.py_mom) : item_s1.py_mom;
		sb_c.z       = item_s1.z_pos;
		sb_c.dp      = item_s1.dp_over_p;
	end

	logic                 vld_s2;
	logic [32:0]          mag_s2;
	rem_sb_t              sb_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= mag_c;
		sb_s2  <= sb_c;
	end

	// ---- remainder of |dividend| by the bucket length
	logic                 rem_vld;
	logic [LBB_LEN_W-1:0] rem_val;
	rem_sb_t              rem_sb;

	lbb_rem #(
		.NB (LBB_REM_NB),
		.DW (LBB_LEN_W),
		.SBW($bits(rem_sb_t))
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (vld_s2),
		.in_num (mag_s2),
		.in_den (bucket_length_q),
		.in_sb  (sb_s2),
		.out_vld(rem_vld),
		.out_rem(rem_val),
		.out_sb (rem_sb)
	);

	// ---- stage 3: reflected z, squares
	logic signed [33:0] srem_c, hx_c, znew_c;

	always_comb begin
		srem_c = rem_sb.rneg ? -34'(rem_val) : 34'(rem_val);
		hx_c   = 34'(rem_sb.half);
		znew_c = rem_sb.pos ? (hx_c - srem_c) : (-hx_c - srem_c);
	end

	logic        vld_s3, outside_s3;
	logic [63:0] d2_s3, px2_s3, py2_s3;
	logic [31:0] znew_s3, z_s3, dp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= rem_vld;
		end
	end

	always_ff @(posedge clk) begin
		outside_s3 <= rem_sb.outside;
		d2_s3      <= 64'(rem_sb.ad) * 64'(rem_sb.ad);
		px2_s3     <= 64'(rem_sb.apx) * 64'(rem_sb.apx);
		py2_s3     <= 64'(rem_sb.apy) * 64'(rem_sb.apy);
		znew_s3    <= znew_c[31:0];
		z_s3       <= rem_sb.z;
		dp_s3      <= rem_sb.dp;
	end

	// ---- stage 4: inner root argument, clamp below zero
	logic [63:0] t2_c;
	assign t2_c = px2_s3 + py2_s3;

	logic        vld_s4;
	logic [63:0] inner_s4;
	isq1_sb_t    sb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sb_s4.outside <= outside_s3;
		sb_s4.err     <= t2_c > d2_s3;
		sb_s4.d2      <= d2_s3;
		sb_s4.z_new   <= znew_s3;
		sb_s4.z       <= z_s3;
		sb_s4.dp      <= dp_s3;
		inner_s4      <= (t2_c > d2_s3) ? 64'd0 : (d2_s3 - t2_c);
	end

	logic        isq1_vld;
	logic [31:0] isq1_root;
	isq1_sb_t    isq1_sb;

	lbb_isqrt #(
		.W  (LBB_SQ_W),
		.SBW($bits(isq1_sb_t))
	) u_isqrt_inner (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s4),
		.in_x    (inner_s4),
		.in_sb   (sb_s4),
		.out_vld (isq1_vld),
		.out_root(isq1_root),
		.out_sb  (isq1_sb)
	);

	// ---- stage 5: outer root argument 4 + d2 - 4*s, floor at zero
	logic [63:0] a_c, b_c;
	assign a_c = FOUR_SQ + isq1_sb.d2;
	assign b_c = 64'(isq1_root) << (MOM_FRAC_BITS + 2);

	logic        vld_s5;
	logic [63:0] outer_s5;
	isq2_sb_t    sb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= isq1_vld;
		end
	end

	always_ff @(posedge clk) begin
		outer_s5      <= (a_c >= b_c) ? (a_c - b_c) : 64'd0;
		sb_s5.outside <= isq1_sb.outside;
		sb_s5.err     <= isq1_sb.err;
		sb_s5.z_new   <= isq1_sb.z_new;
		sb_s5.z       <= isq1_sb.z;
		sb_s5.dp      <= isq1_sb.dp;
	end

	logic        isq2_vld;
	logic [31:0] isq2_root;
	isq2_sb_t    isq2_sb;

	lbb_isqrt #(
		.W  (LBB_SQ_W),
		.SBW($bits(isq2_sb_t))
	) u_isqrt_outer (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s5),
		.in_x    (outer_s5),
		.in_sb   (sb_s5),
		.out_vld (isq2_vld),
		.out_root(isq2_root),
		.out_sb  (isq2_sb)
	);

	// ---- output: subtract 1.0, saturate, pick pass or reflect
	logic signed [33:0] dpn_c;
	logic [31:0]        dpsat_c;
	result_t            res_c;

	always_comb begin
		dpn_c   = 34'(isq2_root) - 34'(ONE33);
		dpsat_c = (dpn_c > 34'sh7FFFFFFF) ? 32'h7FFF_FFFF : dpn_c[31:0];
		if (isq2_sb.outside) begin
			res_c.z_out          = isq2_sb.z_new;
			res_c.dp_out         = dpsat_c;
			res_c.reflected      = 1'b1;
			res_c.momentum_error = isq2_sb.err;
		end else begin
			res_c.z_out          = isq2_sb.z;
			res_c.dp_out         = isq2_sb.dp;
			res_c.reflected      = 1'b0;
			res_c.momentum_error = 1'b0;
		end
	end

	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= isq2_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
